/* sv/memory_region_map_engine_assert.svh */
// Assertion macros for the memory region map engine checker.
// Depends on nothing; included by the checker file only.
`ifndef MEMORY_REGION_MAP_ENGINE_ASSERT_SVH
`define MEMORY_REGION_MAP_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define MRM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("memory region map engine: same-cycle check failed");

// Next-cycle implication, disabled while reset is low
`define MRM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("memory region map engine: next-cycle check failed");

`endif

/* sv/mrm_pkg.sv */
// Shared types and constants of the memory region map engine.
// No dependencies; used by mrm_scan, the top level and the checker through mrm_pkg:: names.
`default_nettype none

package mrm_pkg;

    // Table geometry
    localparam int MAX_ENTRIES = 128;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W       = (CNT_W > 8) ? CNT_W : 8;

    // Page size 4096 bytes, page counts are 32 bits wide
    localparam int PAGE_SHIFT  = $clog2(4096);

    localparam logic [31:0] TYPE_AVAILABLE = 32'd1;

    typedef enum logic [2:0] {
        MODE_CLEAR  = 3'd0,
        MODE_APPEND = 3'd1,
        MODE_FIND   = 3'd2,
        MODE_CHECK  = 3'd3,
        MODE_READ   = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INDEX    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_FIN
    } t_state;

    // One table row as stored in the entry RAM
    typedef struct packed {
        logic [63:0] base;
        logic [63:0] length;
        logic [31:0] rtype;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Operands of a find or check scan, fixed for the whole transaction
    typedef struct packed {
        logic        find;
        logic [63:0] am1;
        logic [63:0] qsize;
        logic [63:0] qaddr;
        logic [63:0] qend;
    } t_scan_cmd;

    // Scan unit status toward the sequencer
    typedef struct packed {
        logic        hit;
        logic        busy;
        logic [63:0] addr;
    } t_scan_res;

    // Complete result transaction
    typedef struct packed {
        logic [63:0] found_address;
        logic        in_available;
        logic [63:0] entry_base_out;
        logic [63:0] entry_length_out;
        logic [31:0] entry_type_out;
        t_status     status;
        logic [63:0] mapped_bytes;
        logic [63:0] free_bytes;
        logic [63:0] held_bytes;
        logic [31:0] mapped_pages;
        logic [31:0] free_pages;
        logic [7:0]  entry_count;
    } t_result;

endpackage

`default_nettype wire

/* sv/mrm_chan_if.sv */
// Valid/ready channel interfaces of the memory region map engine.
// No dependencies; request channel and result channel.
`default_nettype none

// Request channel
interface mrm_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [63:0] region_base;
    logic [63:0] region_length;
    logic [31:0] region_type;
    logic [63:0] query_address;
    logic [63:0] query_size;
    logic [63:0] alignment;
    logic [7:0]  entry_index;

    modport source (
        output valid, mode, region_base, region_length, region_type,
               query_address, query_size, alignment, entry_index,
        input  ready
    );
    modport sink (
        input  valid, mode, region_base, region_length, region_type,
               query_address, query_size, alignment, entry_index,
        output ready
    );
endinterface

// Result channel
interface mrm_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] found_address;
    logic        in_available;
    logic [63:0] entry_base_out;
    logic [63:0] entry_length_out;
    logic [31:0] entry_type_out;
    logic [1:0]  status;
    logic [63:0] mapped_bytes;
    logic [63:0] free_bytes;
    logic [63:0] held_bytes;
    logic [31:0] mapped_pages;
    logic [31:0] free_pages;
    logic [7:0]  entry_count;

    modport source (
        output valid, found_address, in_available, entry_base_out,
               entry_length_out, entry_type_out, status, mapped_bytes,
               free_bytes, held_bytes, mapped_pages,
               free_pages, entry_count,
        input  ready
    );
    modport sink (
        input  valid, found_address, in_available, entry_base_out,
               entry_length_out, entry_type_out, status, mapped_bytes,
               free_bytes, held_bytes, mapped_pages,
               free_pages, entry_count,
        output ready
    );
endinterface

`default_nettype wire

/* sv/mrm_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM.
// No dependencies; read data is registered.
`default_nettype none

module mrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_we,
    input  wire logic [AW-1:0]          i_waddr,
    input  wire logic [WIDTH-1:0]       i_wdata,
    input  wire logic [AW-1:0]          i_raddr,
    output logic      [WIDTH-1:0]       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/mrm_scan.sv */
// Two-stage compare pipeline for find and check scans over table rows.
// Depends on mrm_pkg (t_entry, t_scan_cmd, t_scan_res, TYPE_AVAILABLE).
`default_nettype none

module mrm_scan (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_flush,
    input  wire logic                  i_valid,
    input  wire mrm_pkg::t_entry       i_entry,
    input  wire mrm_pkg::t_scan_cmd    i_cmd,
    output mrm_pkg::t_scan_res         o_res
);

    logic        r_v1;
    logic        r_ok;
    logic [63:0] r_addr;
    logic [63:0] r_lim;

    logic        n_ok;
    logic [63:0] n_addr;
    logic [63:0] n_lim;
    logic        fits;

    // Stage 1: aligned base, region end, type and coarse size/start test
    always_comb begin
        n_addr = (i_entry.base + i_cmd.am1) & ~i_cmd.am1;
        n_lim  = i_entry.base + i_entry.length;
        n_ok   = (i_entry.rtype == mrm_pkg::TYPE_AVAILABLE) &&
                 (i_cmd.find ? (i_entry.length >= i_cmd.qsize)
                             : (i_cmd.qaddr >= i_entry.base));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid && !i_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_ok   <= n_ok;
            r_addr <= n_addr;
            r_lim  <= n_lim;
        end
    end

    // Stage 2: end of requested range against region end (mod 2^64)
    always_comb begin
        fits = i_cmd.find ? ((r_addr + i_cmd.qsize) <= r_lim)
                          : (i_cmd.qend <= r_lim);
        o_res.hit  = r_v1 && r_ok && fits;
        o_res.busy = r_v1;
        o_res.addr = r_addr;
    end

endmodule

`default_nettype wire

/* sv/memory_region_map_engine.sv */
// Top level of the memory region map engine: sequencer, totals, output register.
// Depends on mrm_pkg, mrm_chan_if, mrm_ram and mrm_scan.
//
// The engine holds up to MAX_ENTRIES (128) regions in one entry RAM with a
// registered read port and handles one request transaction at a time.
// Clear, append and the unused modes pass from acceptance through S_FIN
// back to S_IDLE; read passes through S_READ and then S_FIN. Find and check
// walk the stored rows in order through the single RAM read port, one row
// per cycle, followed by a two-stage compare pipeline; they read every
// stored row when no row matches and end early when a matching row is found.
// A finished result sits in an output register while the next request is
// accepted; the engine only waits on the result side (in S_FIN) when a
// second result is ready before the first was taken. Rows that were never
// appended hold undefined data and are never read, so there is no clearing
// pass after reset.
`default_nettype none

module memory_region_map_engine (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mrm_in_if.sink      i_in,
    mrm_out_if.source   o_out
);

    localparam int IDX_W = mrm_pkg::IDX_W;
    localparam int CNT_W = mrm_pkg::CNT_W;
    localparam int CMP_W = mrm_pkg::CMP_W;

    mrm_pkg::t_state    r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [63:0]        r_sum_total, n_sum_total;
    logic [63:0]        r_sum_avail, n_sum_avail;
    logic [CNT_W-1:0]   r_issue, n_issue;
    logic               r_rd_v, n_rd_v;
    mrm_pkg::t_scan_cmd r_cmd, n_cmd;
    mrm_pkg::t_result   r_res, n_res;
    mrm_pkg::t_result   r_out, n_out;
    logic               r_out_valid;

    logic               accept;
    logic               full;
    logic               idx_ok;
    logic [CMP_W-1:0]   idx_ext;
    logic [CMP_W-1:0]   cnt_ext;
    logic               issue;
    logic               load;
    logic               flush;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [IDX_W-1:0]   ram_raddr;
    mrm_pkg::t_entry    ram_wdata;
    mrm_pkg::t_entry    ram_rdata;
    mrm_pkg::t_scan_res scan_res;

    // Entry RAM
    mrm_ram #(
        .WIDTH (mrm_pkg::ENTRY_W),
        .DEPTH (mrm_pkg::MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Compare pipeline fed from the RAM read port
    mrm_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flush (flush),
        .i_valid (r_rd_v && (r_state == mrm_pkg::S_SCAN)),
        .i_entry (ram_rdata),
        .i_cmd   (r_cmd),
        .o_res   (scan_res)
    );

    // Handshake and shared compares
    assign i_in.ready = (r_state == mrm_pkg::S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign full       = (r_count == CNT_W'(mrm_pkg::MAX_ENTRIES));
    assign idx_ext    = CMP_W'(i_in.entry_index);
    assign cnt_ext    = CMP_W'(r_count);
    assign idx_ok     = (idx_ext < cnt_ext);
    assign load       = (r_state == mrm_pkg::S_FIN) && (!r_out_valid || o_out.ready);

    assign ram_wdata.base   = i_in.region_base;
    assign ram_wdata.length = i_in.region_length;
    assign ram_wdata.rtype  = i_in.region_type;
    assign ram_waddr        = r_count[IDX_W-1:0];

    // Sequencer: next state, table updates, RAM reads
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sum_total = r_sum_total;
        n_sum_avail = r_sum_avail;
        n_issue     = r_issue;
        n_rd_v      = 1'b0;
        n_cmd       = r_cmd;
        n_res       = r_res;
        ram_we      = 1'b0;
        ram_raddr   = r_issue[IDX_W-1:0];
        issue       = 1'b0;
        flush       = 1'b0;

        case (r_state)
            mrm_pkg::S_IDLE: begin
                if (accept) begin
                    n_res        = '0;
                    n_res.status = mrm_pkg::ST_OK;
                    n_cmd.find   = (i_in.mode == mrm_pkg::MODE_FIND);
                    n_cmd.am1    = i_in.alignment - 64'd1;
                    n_cmd.qsize  = i_in.query_size;
                    n_cmd.qaddr  = i_in.query_address;
                    n_cmd.qend   = i_in.query_address + i_in.query_size;
                    n_issue      = '0;
                    flush        = 1'b1;
                    n_state      = mrm_pkg::S_FIN;
                    case (mrm_pkg::t_mode'(i_in.mode))
                        mrm_pkg::MODE_CLEAR: begin
                            n_count     = '0;
                            n_sum_total = '0;
                            n_sum_avail = '0;
                        end
                        mrm_pkg::MODE_APPEND: begin
                            if (!full) begin
                                ram_we      = 1'b1;
                                n_count     = r_count + CNT_W'(1);
                                n_sum_total = r_sum_total + i_in.region_length;
                                if (i_in.region_type == mrm_pkg::TYPE_AVAILABLE) begin
                                    n_sum_avail = r_sum_avail + i_in.region_length;
                                end
                            end else begin
                                n_res.status = mrm_pkg::ST_FULL;
                            end
                        end
                        mrm_pkg::MODE_FIND, mrm_pkg::MODE_CHECK: begin
                            n_state = mrm_pkg::S_SCAN;
                        end
                        mrm_pkg::MODE_READ: begin
                            if (idx_ok) begin
                                ram_raddr = idx_ext[IDX_W-1:0];
                                n_state   = mrm_pkg::S_READ;
                            end else begin
                                n_res.status = mrm_pkg::ST_INDEX;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            mrm_pkg::S_READ: begin
                n_res.entry_base_out   = ram_rdata.base;
                n_res.entry_length_out = ram_rdata.length;
                n_res.entry_type_out   = ram_rdata.rtype;
                n_state                = mrm_pkg::S_FIN;
            end

            mrm_pkg::S_SCAN: begin
                if (scan_res.hit) begin
                    // first match in table order ends the scan
                    if (r_cmd.find) begin
                        n_res.found_address = scan_res.addr;
                    end else begin
                        n_res.in_available = 1'b1;
                    end
                    n_state = mrm_pkg::S_FIN;
                end else begin
                    issue     = (r_issue < r_count);
                    ram_raddr = r_issue[IDX_W-1:0];
                    if (issue) begin
                        n_issue = r_issue + CNT_W'(1);
                    end
                    n_rd_v = issue;
                    // all rows issued and pipeline drained with no match
                    if (!issue && !r_rd_v && !scan_res.busy) begin
                        n_res.status = r_cmd.find ? mrm_pkg::ST_NOTFOUND
                                                  : mrm_pkg::ST_OK;
                        n_state      = mrm_pkg::S_FIN;
                    end
                end
            end

            mrm_pkg::S_FIN: begin
                if (load) begin
                    n_state = mrm_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = mrm_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mrm_pkg::S_IDLE;
            r_count     <= '0;
            r_sum_total <= '0;
            r_sum_avail <= '0;
            r_issue     <= '0;
            r_rd_v      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sum_total <= n_sum_total;
            r_sum_avail <= n_sum_avail;
            r_issue     <= n_issue;
            r_rd_v      <= n_rd_v;
        end
    end

    // Per-transaction operands and partial result
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_res <= n_res;
    end

    // Output register: totals are attached when the result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        n_out              = r_res;
        n_out.mapped_bytes = r_sum_total;
        n_out.free_bytes   = r_sum_avail;
        n_out.held_bytes   = r_sum_total - r_sum_avail;
        n_out.mapped_pages = r_sum_total[mrm_pkg::PAGE_SHIFT +: 32];
        n_out.free_pages   = r_sum_avail[mrm_pkg::PAGE_SHIFT +: 32];
        n_out.entry_count  = cnt_ext[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.found_address    = r_out.found_address;
    assign o_out.in_available     = r_out.in_available;
    assign o_out.entry_base_out   = r_out.entry_base_out;
    assign o_out.entry_length_out = r_out.entry_length_out;
    assign o_out.entry_type_out   = r_out.entry_type_out;
    assign o_out.status           = r_out.status;
    assign o_out.mapped_bytes     = r_out.mapped_bytes;
    assign o_out.free_bytes       = r_out.free_bytes;
    assign o_out.held_bytes       = r_out.held_bytes;
    assign o_out.mapped_pages     = r_out.mapped_pages;
    assign o_out.free_pages       = r_out.free_pages;
    assign o_out.entry_count      = r_out.entry_count;

endmodule

`default_nettype wire

/* sv/mrm_checker.sv */
// Port-level assertion checker for the memory region map engine, with its bind.
// Depends on mrm_pkg and memory_region_map_engine_assert.svh.
`default_nettype none
`include "memory_region_map_engine_assert.svh"

module mrm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_in_available,
    input wire logic [1:0]  i_status,
    input wire logic [63:0] i_mapped_bytes,
    input wire logic [63:0] i_free_bytes,
    input wire logic [63:0] i_held_bytes,
    input wire logic [31:0] i_mapped_pages,
    input wire logic [7:0]  i_entry_count
);

    logic held_match;
    logic pages_match;
    logic full_seen;
    logic full_count;
    logic inside_seen;
    logic status_ok;

    // Terms used by the assertions below
    assign held_match  = (i_held_bytes == i_mapped_bytes - i_free_bytes);
    assign pages_match = (i_mapped_pages == i_mapped_bytes[mrm_pkg::PAGE_SHIFT +: 32]);
    assign full_seen   = i_out_valid && (i_status == mrm_pkg::ST_FULL);
    assign full_count  = (i_entry_count == 8'(mrm_pkg::MAX_ENTRIES));
    assign inside_seen = i_out_valid && i_in_available;
    assign status_ok   = (i_status == mrm_pkg::ST_OK);

    // A result transaction stays offered until taken
    `MRM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // Reserved share is total minus available, modulo 2^64
    `MRM_ASSERT_IMP(a_reserved, i_clk, i_rst_n, i_out_valid, held_match)

    // Page count follows the byte total
    `MRM_ASSERT_IMP(a_pages, i_clk, i_rst_n, i_out_valid, pages_match)

    // Table full is only reported with a full table
    `MRM_ASSERT_IMP(a_full_count, i_clk, i_rst_n, full_seen, full_count)

    // A range found inside a region always comes with status ok
    `MRM_ASSERT_IMP(a_inside_ok, i_clk, i_rst_n, inside_seen, status_ok)

endmodule

bind memory_region_map_engine mrm_checker u_mrm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_in_available (o_out.in_available),
    .i_status       (o_out.status),
    .i_mapped_bytes (o_out.mapped_bytes),
    .i_free_bytes   (o_out.free_bytes),
    .i_held_bytes   (o_out.held_bytes),
    .i_mapped_pages (o_out.mapped_pages),
    .i_entry_count  (o_out.entry_count)
);

`default_nettype wire
